// ----- hw/rtl/multichannel_rfid_frame_assembler_top_assert.svh -----
// Assertion macros for the frame assembler top level.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef MULTICHANNEL_RFID_FRAME_ASSEMBLER_TOP_ASSERT_SVH
`define MULTICHANNEL_RFID_FRAME_ASSEMBLER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define MRFA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MRFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/mrfa_pkg.sv -----
// ----------------------------------------------------------------------------
// mrfa_pkg
// Shared types and constants of the multichannel frame assembler.
// ----------------------------------------------------------------------------
package mrfa_pkg;

    localparam int NUM_CHIPS_DEF      = 8;
    localparam int PORTS_PER_CHIP_DEF = 4;

    localparam int FRAME_LEN = 14;
    localparam int CNT_W     = 4;

    localparam logic [7:0] START_BYTE = 8'h02;
    localparam logic [7:0] LF_BYTE    = 8'h0a;
    localparam logic [7:0] END_BYTE   = 8'h03;

    localparam logic [CNT_W-1:0] POS_FIRST  = 4'd0;
    localparam logic [CNT_W-1:0] POS_ZEROED = 4'd11;
    localparam logic [CNT_W-1:0] POS_LF     = 4'd12;
    localparam logic [CNT_W-1:0] POS_END    = 4'd13;

    typedef struct packed {
        logic [2:0] chip_select;
        logic [1:0] port_index;
        logic [7:0] rx_byte;
        logic       break_seen;
    } in_item_t;

    typedef struct packed {
        logic [2:0] out_chip;
        logic [1:0] out_port;
        logic [3:0] byte_position;
        logic [7:0] frame_byte;
        logic       frame_last;
    } out_item_t;

    // Per-channel status word kept in the status memory.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             start_ok;
        logic             lf_ok;
    } chan_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_EMIT
    } state_t;

endpackage

// ----- hw/rtl/multichannel_rfid_frame_assembler_top.sv -----
// Order: a byte is taken in IDLE and stored in UPDATE in the next cycle; a byte that completes a
//   valid frame then moves to EMIT, which reads the frame store whenever the result slot is free.
// Flow: no new byte is taken while the read-modify-write of the channel status memory runs;
//   a completing byte then holds the input while 14 results stream, one per accepted result.
// Reset: state machine, status valid bits and result valid clear at once; the frame store
//   is not cleared, since every frame is fully rewritten before it is read.
// ----------------------------------------------------------------------------
// multichannel_rfid_frame_assembler_top
// Per-channel STX/ETX deframer: collects 14-byte frames for each chip/port channel
// in a shared frame store and streams out every frame that passes the check.
// ----------------------------------------------------------------------------
`include "multichannel_rfid_frame_assembler_top_assert.svh"

module multichannel_rfid_frame_assembler_top
#(
    parameter int NUM_CHIPS      = mrfa_pkg::NUM_CHIPS_DEF,
    parameter int PORTS_PER_CHIP = mrfa_pkg::PORTS_PER_CHIP_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  mrfa_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output mrfa_pkg::out_item_t result
);

    localparam int NUM_CH    = NUM_CHIPS * PORTS_PER_CHIP;
    localparam int CH_W      = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
    localparam int MEM_DEPTH = NUM_CH * mrfa_pkg::FRAME_LEN;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int CNT_W     = mrfa_pkg::CNT_W;

    // Memories
    logic [7:0]           frame_mem [MEM_DEPTH];
    mrfa_pkg::chan_stat_t stat_mem  [NUM_CH];
    logic [7:0]           frame_rd_data_reg;
    mrfa_pkg::chan_stat_t stat_rd_data_reg;

    // Control and item registers
    mrfa_pkg::state_t  state_reg, state_next;
    logic [NUM_CH-1:0] stat_valid_reg, stat_valid_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic [2:0]        chip_reg, chip_next;
    logic [1:0]        port_reg, port_next;
    logic [7:0]        byte_reg, byte_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [CNT_W-1:0]  emit_pos_reg, emit_pos_next;

    // Result register
    logic              res_valid_reg, res_valid_next;
    logic [CNT_W-1:0]  res_pos_reg, res_pos_next;
    logic [2:0]        res_chip_reg, res_chip_next;
    logic [1:0]        res_port_reg, res_port_next;

    logic                 item_acc;
    logic                 item_keep;
    logic [CH_W-1:0]      ch_in;
    logic [ADDR_W-1:0]    base_in;
    mrfa_pkg::chan_stat_t cur_stat;
    mrfa_pkg::chan_stat_t stat_wdata;
    logic [CNT_W-1:0]     wr_pos;
    logic                 start_ok_new;
    logic                 lf_ok_new;
    logic                 frame_full;
    logic                 frame_good;
    logic                 stat_rd_en;
    logic                 stat_we;
    logic                 fm_we;
    logic [ADDR_W-1:0]    fm_waddr;
    logic                 fm_rd_en;
    logic [ADDR_W-1:0]    fm_raddr;

    // Input decode
    always_comb
    begin
        item_acc  = item_valid && item_ready;
        item_keep = !item.break_seen
                    && (int'(item.chip_select) < NUM_CHIPS)
                    && (int'(item.port_index) < PORTS_PER_CHIP);
        ch_in     = CH_W'(int'(item.chip_select) * PORTS_PER_CHIP + int'(item.port_index));
        base_in   = ADDR_W'(int'(ch_in) * mrfa_pkg::FRAME_LEN);
    end

    // Update of one channel from the status word read in the previous cycle
    always_comb
    begin
        cur_stat = stat_valid_reg[ch_reg] ? stat_rd_data_reg : '0;
        if (byte_reg == mrfa_pkg::START_BYTE
            || int'(cur_stat.count) >= mrfa_pkg::FRAME_LEN)
        begin
            wr_pos = mrfa_pkg::POS_FIRST;
        end
        else
        begin
            wr_pos = cur_stat.count;
        end
        start_ok_new = (wr_pos == mrfa_pkg::POS_FIRST) ? (byte_reg == mrfa_pkg::START_BYTE)
                                                       : cur_stat.start_ok;
        lf_ok_new    = (wr_pos == mrfa_pkg::POS_LF) ? (byte_reg == mrfa_pkg::LF_BYTE)
                                                    : cur_stat.lf_ok;
        frame_full   = (wr_pos == mrfa_pkg::POS_END);
        frame_good   = start_ok_new && lf_ok_new && (byte_reg == mrfa_pkg::END_BYTE);
        // Restart the count once the frame is full, good or bad.
        if (frame_full)
        begin
            stat_wdata = '0;
        end
        else
        begin
            stat_wdata.count    = wr_pos + CNT_W'(1);
            stat_wdata.start_ok = start_ok_new;
            stat_wdata.lf_ok    = lf_ok_new;
        end
        fm_waddr = base_reg + ADDR_W'(wr_pos);
        fm_raddr = base_reg + ADDR_W'(emit_pos_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mrfa_pkg::ST_IDLE:
            begin
                if (item_acc && item_keep)
                begin
                    state_next = mrfa_pkg::ST_UPDATE;
                end
            end
            mrfa_pkg::ST_UPDATE:
            begin
                if (frame_full && frame_good)
                begin
                    state_next = mrfa_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = mrfa_pkg::ST_IDLE;
                end
            end
            mrfa_pkg::ST_EMIT:
            begin
                if (fm_rd_en && emit_pos_reg == mrfa_pkg::POS_END)
                begin
                    state_next = mrfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mrfa_pkg::ST_IDLE;
            end
        endcase
    end

    // State machine outputs
    always_comb
    begin
        item_ready = 1'b0;
        stat_rd_en = 1'b0;
        stat_we    = 1'b0;
        fm_we      = 1'b0;
        fm_rd_en   = 1'b0;
        case (state_reg)
            mrfa_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                stat_rd_en = item_acc && item_keep;
            end
            mrfa_pkg::ST_UPDATE:
            begin
                stat_we = 1'b1;
                fm_we   = 1'b1;
            end
            mrfa_pkg::ST_EMIT:
            begin
                // Advance only when the result slot frees up in this cycle.
                fm_rd_en = !res_valid_reg || result_ready;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    // Register next values
    always_comb
    begin
        ch_next         = ch_reg;
        chip_next       = chip_reg;
        port_next       = port_reg;
        byte_next       = byte_reg;
        base_next       = base_reg;
        stat_valid_next = stat_valid_reg;
        emit_pos_next   = emit_pos_reg;
        res_pos_next    = res_pos_reg;
        res_chip_next   = res_chip_reg;
        res_port_next   = res_port_reg;
        res_valid_next  = res_valid_reg && !result_ready;

        if (stat_rd_en)
        begin
            ch_next   = ch_in;
            chip_next = item.chip_select;
            port_next = item.port_index;
            byte_next = item.rx_byte;
            base_next = base_in;
        end
        if (stat_we)
        begin
            stat_valid_next[ch_reg] = 1'b1;
            emit_pos_next           = mrfa_pkg::POS_FIRST;
        end
        if (fm_rd_en)
        begin
            emit_pos_next  = emit_pos_reg + CNT_W'(1);
            res_valid_next = 1'b1;
            res_pos_next   = emit_pos_reg;
            res_chip_next  = chip_reg;
            res_port_next  = port_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mrfa_pkg::ST_IDLE;
            stat_valid_reg <= '0;
            emit_pos_reg   <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            stat_valid_reg <= stat_valid_next;
            emit_pos_reg   <= emit_pos_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg       <= ch_next;
        chip_reg     <= chip_next;
        port_reg     <= port_next;
        byte_reg     <= byte_next;
        base_reg     <= base_next;
        res_pos_reg  <= res_pos_next;
        res_chip_reg <= res_chip_next;
        res_port_reg <= res_port_next;
    end

    // Channel status memory
    always_ff @(posedge clk)
    begin
        if (stat_we)
        begin
            stat_mem[ch_reg] <= stat_wdata;
        end
        if (stat_rd_en)
        begin
            stat_rd_data_reg <= stat_mem[ch_in];
        end
    end

    // Frame store
    always_ff @(posedge clk)
    begin
        if (fm_we)
        begin
            frame_mem[fm_waddr] <= byte_reg;
        end
        if (fm_rd_en)
        begin
            frame_rd_data_reg <= frame_mem[fm_raddr];
        end
    end

    always_comb
    begin
        result_valid         = res_valid_reg;
        result.out_chip      = res_chip_reg;
        result.out_port      = res_port_reg;
        result.byte_position = res_pos_reg;
        result.frame_byte    = (res_pos_reg == mrfa_pkg::POS_ZEROED) ? 8'h00
                                                                     : frame_rd_data_reg;
        result.frame_last    = (res_pos_reg == mrfa_pkg::POS_END);
    end

    `MRFA_ASSERT_SAME(a_read_slot_free, fm_rd_en, !res_valid_reg || result_ready, "frame read overruns pending result")
    `MRFA_ASSERT_NEXT(a_kept_byte_updates, item_acc && item_keep, state_reg == mrfa_pkg::ST_UPDATE, "accepted byte did not reach update")
    `MRFA_ASSERT_NEXT(a_good_frame_emits, state_reg == mrfa_pkg::ST_UPDATE && frame_full && frame_good, state_reg == mrfa_pkg::ST_EMIT && emit_pos_reg == mrfa_pkg::POS_FIRST, "good frame did not start emission")
    `MRFA_ASSERT_SAME(a_count_in_range, stat_we, int'(stat_wdata.count) < mrfa_pkg::FRAME_LEN, "fill count out of range")

endmodule

// ----- tb/mrfa_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mrfa_checker
// Watches all channels of the frame assembler. Keeps its own copy of every
// channel's frame and fill level, predicts the bytes of each valid frame, and
// compares accepted results field by field in order.
// ----------------------------------------------------------------------------
module mrfa_checker
#(
    parameter int NUM_CHIPS      = mrfa_pkg::NUM_CHIPS_DEF,
    parameter int PORTS_PER_CHIP = mrfa_pkg::PORTS_PER_CHIP_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_ready,
    input  mrfa_pkg::in_item_t  item,
    input  logic                result_valid,
    input  logic                result_ready,
    input  mrfa_pkg::out_item_t result,
    output int                  mismatches,
    output int                  outstanding,
    output int                  frames_seen
);
    import mrfa_pkg::*;

    localparam int NUM_CH = NUM_CHIPS * PORTS_PER_CHIP;

    logic [7:0] frame_copy [NUM_CH][FRAME_LEN];
    int         fill_level [NUM_CH];
    out_item_t  frame_byte_q [$];
    int         err_count;
    int         frames_done;

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_count++;
        end
    endtask

    task automatic take_rx_byte(input in_item_t it);
        int        ch;
        int        pos;
        int        k;
        out_item_t o;
        if (it.break_seen)
            return;
        if (it.chip_select >= NUM_CHIPS || it.port_index >= PORTS_PER_CHIP)
            return;
        ch  = it.chip_select * PORTS_PER_CHIP + it.port_index;
        pos = fill_level[ch];
        if (it.rx_byte == START_BYTE || pos >= FRAME_LEN)
            pos = 0;
        frame_copy[ch][pos] = it.rx_byte;
        pos++;
        if (pos < FRAME_LEN)
        begin
            fill_level[ch] = pos;
            return;
        end
        // full frame: restart the count whether or not it passes
        fill_level[ch] = 0;
        if (frame_copy[ch][POS_FIRST] != START_BYTE || frame_copy[ch][POS_LF] != LF_BYTE ||
            frame_copy[ch][POS_END] != END_BYTE)
            return;
        for (k = 0; k < FRAME_LEN; k++)
        begin
            o.out_chip      = it.chip_select;
            o.out_port      = it.port_index;
            o.byte_position = 4'(k);
            o.frame_byte    = (k == POS_ZEROED) ? 8'h00 : frame_copy[ch][k];
            o.frame_last    = (k == FRAME_LEN - 1);
            frame_byte_q.push_back(o);
        end
    endtask

    task automatic take_result(input out_item_t got);
        out_item_t want;
        if (frame_byte_q.size() == 0)
        begin
            $error("result with nothing expected: chip %0d port %0d position %0d byte %0h",
                   got.out_chip, got.out_port, got.byte_position, got.frame_byte);
            err_count++;
            return;
        end
        want = frame_byte_q.pop_front();
        check_field("out_chip", want.out_chip, got.out_chip);
        check_field("out_port", want.out_port, got.out_port);
        check_field("byte_position", want.byte_position, got.byte_position);
        check_field("frame_byte", want.frame_byte, got.frame_byte);
        check_field("frame_last", want.frame_last, got.frame_last);
        if (want.frame_last)
            frames_done++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (frame_copy[c, p])
                frame_copy[c][p] = 8'h00;
            foreach (fill_level[c])
                fill_level[c] = 0;
            frame_byte_q.delete();
            err_count   = 0;
            frames_done = 0;
            mismatches  <= 0;
            outstanding <= 0;
            frames_seen <= 0;
        end
        else
        begin
            // retire results before predicting: a new byte never feeds this edge
            if (result_valid === 1'b1 && result_ready)
                take_result(result);
            if (item_valid && item_ready === 1'b1)
                take_rx_byte(item);
            mismatches  <= err_count;
            outstanding <= frame_byte_q.size();
            frames_seen <= frames_done;
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Feeds tagged UART bytes to the frame assembler: a short directed opening,
// then interleaved frames on random channels, good and damaged, with break
// noise, bursty sending, a stalling receiver and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
    import mrfa_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int RANDOM_BYTES   = 125;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int TAIL_CYCLES    = 20;
    localparam int MAX_SLOTS      = 3;
    localparam int SLOT_DEPTH     = 32;

    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_LF,
        FLAW_BAD_END,
        FLAW_SHORT,
        FLAW_RESTART,
        FLAW_NO_START
    } flaw_t;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      item_valid   = 1'b0;
    in_item_t  item         = '0;
    logic      result_ready = 1'b0;
    logic      item_ready;
    logic      result_valid;
    out_item_t result;

    int mismatches;
    int outstanding;
    int frames_seen;

    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;

    int burst_left     = 0;
    int bytes_offered  = 0;
    int breaks_offered = 0;
    int data_bytes     = 0;

    logic [7:0] slot_data [MAX_SLOTS][SLOT_DEPTH];
    int         slot_len  [MAX_SLOTS];
    int         slot_pos  [MAX_SLOTS];
    logic [2:0] slot_chip [MAX_SLOTS];
    logic [1:0] slot_port [MAX_SLOTS];

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    multichannel_rfid_frame_assembler_top uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    mrfa_checker u_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .frames_seen  (frames_seen)
    );

    function automatic in_item_t rx_item(input logic [2:0] chip, input logic [1:0] port,
                                         input logic [7:0] data, input logic brk);
        in_item_t it;
        it.chip_select = chip;
        it.port_index  = port;
        it.rx_byte     = data;
        it.break_seen  = brk;
        return it;
    endfunction

    // any byte except the start marker, so it cannot restart a frame
    function automatic logic [7:0] payload_byte();
        logic [7:0] v;
        do
            v = 8'($urandom);
        while (v == START_BYTE);
        return v;
    endfunction

    function automatic in_item_t break_item();
        return rx_item(3'($urandom_range(0, NUM_CHIPS_DEF - 1)),
                       2'($urandom_range(0, PORTS_PER_CHIP_DEF - 1)),
                       ($urandom_range(0, 3) == 0) ? START_BYTE : 8'($urandom), 1'b1);
    endfunction

    // Offer one transaction; gaps fall between bursts of random length.
    task automatic offer(input in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_ready !== 1'b1);
        bytes_offered++;
        if (it.break_seen)
            breaks_offered++;
        else
            data_bytes++;
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic noise_burst();
        int n;
        n = $urandom_range(1, 6);
        repeat (n)
            offer(rx_item(3'($urandom), 2'($urandom),
                          ($urandom_range(0, 4) == 0) ? START_BYTE : 8'($urandom),
                          $urandom_range(0, 3) == 0));
    endtask

    task automatic load_slot(input int s, input flaw_t flaw);
        int         n;
        int         i;
        logic [7:0] v;
        n = 0;
        if (flaw == FLAW_RESTART)
        begin
            // partial frame that the following start byte abandons
            slot_data[s][0] = START_BYTE;
            n = $urandom_range(1, 8);
            for (i = 1; i <= n; i++)
                slot_data[s][i] = payload_byte();
            n++;
        end
        slot_data[s][n] = (flaw == FLAW_NO_START) ? payload_byte() : START_BYTE;
        for (i = 1; i < POS_LF; i++)
            slot_data[s][n + i] = payload_byte();
        slot_data[s][n + POS_LF]  = LF_BYTE;
        slot_data[s][n + POS_END] = END_BYTE;
        if (flaw == FLAW_BAD_LF)
        begin
            do
                v = payload_byte();
            while (v == LF_BYTE);
            slot_data[s][n + POS_LF] = v;
        end
        if (flaw == FLAW_BAD_END)
        begin
            do
                v = payload_byte();
            while (v == END_BYTE);
            slot_data[s][n + POS_END] = v;
        end
        slot_len[s] = (flaw == FLAW_SHORT) ? n + $urandom_range(1, FRAME_LEN - 1)
                                           : n + FRAME_LEN;
        slot_pos[s] = 0;
    endtask

    // Interleave frames of several distinct channels byte by byte.
    task automatic frame_group(input int nslots, input bit clean);
        int    s;
        int    t;
        int    left;
        bit    dup;
        flaw_t flaw;
        left = 0;
        for (s = 0; s < nslots; s++)
        begin
            do
            begin
                slot_chip[s] = 3'($urandom_range(0, NUM_CHIPS_DEF - 1));
                slot_port[s] = 2'($urandom_range(0, PORTS_PER_CHIP_DEF - 1));
                dup = 1'b0;
                for (t = 0; t < s; t++)
                    if (slot_chip[t] == slot_chip[s] && slot_port[t] == slot_port[s])
                        dup = 1'b1;
            end
            while (dup);
            flaw = (clean || $urandom_range(0, 9) < 7)
                 ? FLAW_NONE : flaw_t'($urandom_range(FLAW_BAD_LF, FLAW_NO_START));
            load_slot(s, flaw);
            left += slot_len[s];
        end
        while (left > 0)
        begin
            do
                s = $urandom_range(0, nslots - 1);
            while (slot_pos[s] >= slot_len[s]);
            if (!clean && $urandom_range(0, 11) == 0)
                offer(break_item());
            offer(rx_item(slot_chip[s], slot_port[s], slot_data[s][slot_pos[s]], 1'b0));
            slot_pos[s]++;
            left--;
        end
    endtask

    // Receiver: changing stall patterns, plus one long hold-off on request.
    initial
    begin : receiver
        int mode;
        int mode_left;
        int k;
        mode_left = 0;
        k = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            k++;
            case (mode)
                0:       result_ready <= 1'b1;
                1:       result_ready <= 1'($urandom_range(0, 1));
                2:       result_ready <= (k % 5) < 3;
                default: result_ready <= ($urandom_range(0, 7) == 0);
            endcase
            @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int i;
        int start_count;
        int w;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // partial frame on the lowest channel, then a start byte restarts it
        offer(rx_item(3'd0, 2'd0, START_BYTE, 1'b0));
        offer(rx_item(3'd0, 2'd0, 8'h00, 1'b0));
        offer(rx_item(3'd0, 2'd0, START_BYTE, 1'b0));
        offer(rx_item(3'd0, 2'd0, 8'hff, 1'b1));
        // valid frame on the highest channel, all-ones payload, break byte inside
        offer(rx_item(3'd7, 2'd3, START_BYTE, 1'b0));
        for (i = 1; i < FRAME_LEN; i++)
        begin
            if (i == 6)
                offer(rx_item(3'd7, 2'd3, START_BYTE, 1'b1));
            offer(rx_item(3'd7, 2'd3, (i == POS_LF) ? LF_BYTE :
                                      (i == POS_END) ? END_BYTE : 8'hff, 1'b0));
        end
        wait_idle();

        start_count = data_bytes;
        while (data_bytes - start_count < RANDOM_BYTES)
        begin
            if (!hold_req && data_bytes - start_count >= 60)
            begin
                // hold the receiver while whole frames keep coming: fill the block
                hold_req = 1'b1;
                repeat (3) frame_group(1, 1'b1);
                wait_idle();
            end
            else
            begin
                case ($urandom_range(0, 9))
                    7:       noise_burst();
                    8:       wait_idle();
                    default: frame_group($urandom_range(1, MAX_SLOTS), 1'b0);
                endcase
            end
        end

        item_valid <= 1'b0;
        @(posedge clk);
        for (w = 0; w < DRAIN_LIMIT && outstanding != 0; w++)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (outstanding != 0)
            $error("%0d expected results never arrived", outstanding);

        $display("run covered %0d bytes (%0d break-flagged) and %0d emitted frames",
                 bytes_offered, breaks_offered, frames_seen);
        $display("including interleaved channels, damaged frames and a receiver hold-off");
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- multichannel_rfid_frame_assembler_top.f -----
+incdir+hw/rtl
hw/rtl/mrfa_pkg.sv
hw/rtl/multichannel_rfid_frame_assembler_top.sv
tb/mrfa_checker.sv
tb/tb.sv
